// ===== rtl/sdcs_pkg.sv =====
package sdcs_pkg;

    // default sizing, handed to the top level parameters
    localparam int HISTORY_DEPTH_DEF = 16;
    localparam int MAX_WINDOW_DEF    = 64;
    localparam int MAX_MARGIN_DEF    = 32;

    // swing period limits in ms, and the value history entries start at
    localparam int PERIOD_MIN = 150;
    localparam int PERIOD_MAX = 250;
    localparam int PERIOD_MID = 200;

    // turn offset = avg * 38 / 100, done as avg * (38 * 5243) >> 19
    localparam int TURN_MUL    = 199234;
    localparam int TURN_SHIFT  = 19;
    localparam int TURN_PROD_W = 26;

    // fixed field widths
    localparam int NOW_W      = 32;
    localparam int AVG_W      = 8;
    localparam int STEP_W     = 16;
    localparam int NT_W       = AVG_W + STEP_W;
    localparam int COL_W      = 6;
    localparam int WIN_CFG_W  = 7;
    localparam int MAR_CFG_W  = 6;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN = 1'b1;

    localparam logic [WIN_CFG_W-1:0] WINDOW_RESET = 7'd32;
    localparam logic [MAR_CFG_W-1:0] MARGIN_RESET = 6'd4;

    // request kinds
    localparam logic REQ_START  = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [NOW_W-1:0] now_ms;
        logic             tilt;
    } t_in_item;

    typedef struct packed {
        logic             show_column;
        logic [COL_W-1:0] column_index;
        logic             direction_changed;
        logic             sweep_down;
        logic [NOW_W-1:0] next_time;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic tilt_eval;
        logic avg_store;
        logic turn_eval;
        logic step_eval;
        logic div_nt;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic keep;
        logic div_busy;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/swing_display_column_sequencer_top.sv =====
// Column sequencer for a swinging light display. Each item (start or update, with a
// millisecond time and the tilt level) gives exactly one result: the column or margin
// blank to show, a turn flag with the new sweep direction, and the time of the next
// update. Items are handled one at a time; a result waits in an output register, so
// the next item is taken while it is still unread. Most of the time per item goes to
// one 24-step pass of the serial divider for the next update time; a tilt change that
// yields an in-range period adds a step for the running average. An unread result
// holds the following item in its last step until the output register frees up.
// Window and margin widths are sampled on a start item. No clearing pass follows reset.
module swing_display_column_sequencer_top #(
    parameter int HISTORY_DEPTH = sdcs_pkg::HISTORY_DEPTH_DEF,
    parameter int MAX_WINDOW    = sdcs_pkg::MAX_WINDOW_DEF,
    parameter int MAX_MARGIN    = sdcs_pkg::MAX_MARGIN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sdcs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sdcs_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_in_valid,
    input  sdcs_pkg::t_in_item              i_in_data,
    output logic                            o_in_stall,
    output logic                            o_out_valid,
    output sdcs_pkg::t_out_item             o_out_data,
    input  logic                            i_out_stall
);

    import sdcs_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencing
    sdcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // timing history, position and result datapath
    sdcs_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .MAX_WINDOW    (MAX_WINDOW),
        .MAX_MARGIN    (MAX_MARGIN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // an accepted item closes the input until its result is staged
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after an item was taken");

    // the divider is only started while idle
    a_div_idle_on_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_nt |-> !sts.div_busy)
        else $error("divider started while busy");

    // a result is only staged when the output register frees up
    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result overwrote an unread result");

endmodule

// ===== rtl/sdcs_div.sv =====
module sdcs_div #(
    parameter int DW = 24,
    parameter int VW = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_busy,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DW);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [VW-1:0]    r_rem;
    logic [DW-1:0]    r_quo;
    logic [VW-1:0]    r_dvs;

    logic [VW:0]      trial;
    logic [VW:0]      diff;
    logic             ge;
    logic [VW-1:0]    n_rem;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_quo[DW-1]};
        ge    = (trial >= {1'b0, r_dvs});
        diff  = trial - {1'b0, r_dvs};
        n_rem = ge ? diff[VW-1:0] : trial[VW-1:0];
    end

    // control: one quotient bit per cycle, done pulses after the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operands
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DW-2:0], ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/sdcs_dp.sv =====
module sdcs_dp #(
    parameter int HISTORY_DEPTH = 16,
    parameter int MAX_WINDOW    = 64,
    parameter int MAX_MARGIN    = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sdcs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sdcs_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  sdcs_pkg::t_in_item                  i_in_data,
    input  sdcs_pkg::t_cmd                      i_cmd,
    output sdcs_pkg::t_sts                      o_sts,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output sdcs_pkg::t_out_item                 o_out_data
);

    import sdcs_pkg::*;

    localparam int SL_W   = $clog2(HISTORY_DEPTH);
    localparam int SUM_W  = $clog2(PERIOD_MAX * HISTORY_DEPTH + HISTORY_DEPTH / 2 + 1);
    localparam int LW_W   = $clog2(MAX_WINDOW + 1);
    localparam int LM_W   = $clog2(MAX_MARGIN + 2);
    localparam int TOT_W  = $clog2(MAX_WINDOW + 2 * MAX_MARGIN + 1);
    localparam int POS_W  = $clog2(MAX_WINDOW + MAX_MARGIN + 1) + 1;
    localparam int CWX_W  = WIN_CFG_W + 1;
    localparam int CMX_W  = MAR_CFG_W + 1;

    // average = (sum + depth/2) / depth by an exact reciprocal multiply
    localparam int AVG_SH  = SUM_W + $clog2(HISTORY_DEPTH);
    localparam int AVG_MUL = ((1 << AVG_SH) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;
    localparam int AVG_MW  = SUM_W + 2;
    localparam int AVG_PW  = SUM_W + AVG_MW;

    // step direction codes
    localparam logic signed [1:0] DIR_NONE = 2'sb00;
    localparam logic signed [1:0] DIR_UP   = 2'sb01;
    localparam logic signed [1:0] DIR_DOWN = 2'sb11;

    // clamp the window register to 1..MAX_WINDOW
    function automatic logic [LW_W-1:0] clamp_window(input logic [WIN_CFG_W-1:0] w);
        logic [CWX_W-1:0] wx;
        wx = {1'b0, w};
        if (wx == '0) begin
            wx = CWX_W'(1);
        end else if (wx > CWX_W'(MAX_WINDOW)) begin
            wx = CWX_W'(MAX_WINDOW);
        end
        return LW_W'(wx);
    endfunction

    // clamp the margin register to 0..MAX_MARGIN
    function automatic logic [LM_W-1:0] clamp_margin(input logic [MAR_CFG_W-1:0] m);
        logic [CMX_W-1:0] mx;
        mx = {1'b0, m};
        if (mx > CMX_W'(MAX_MARGIN)) begin
            mx = CMX_W'(MAX_MARGIN);
        end
        return LM_W'(mx);
    endfunction

    // configuration and latched geometry
    logic [WIN_CFG_W-1:0]    r_cfg_win;
    logic [MAR_CFG_W-1:0]    r_cfg_mar;
    logic [LW_W-1:0]         r_lat_w;
    logic [LM_W-1:0]         r_lat_m;

    // item being worked on
    logic                    r_req;
    logic [NOW_W-1:0]        r_now;
    logic                    r_tilt;

    // swing tracking
    logic                    r_last_tilt;
    logic [NOW_W-1:0]        r_swing;
    logic [NOW_W-1:0]        r_tt;
    logic                    r_pend;
    logic                    r_chg;
    logic [STEP_W-1:0]       r_step_cnt;
    logic signed [1:0]       r_dir;
    logic signed [POS_W-1:0] r_pos;

    // period history
    logic [SUM_W-1:0]        r_sum;
    logic [AVG_W-1:0]        r_avg;
    logic [SL_W-1:0]         r_slot;
    logic [HISTORY_DEPTH-1:0] r_hval;
    logic [AVG_W-1:0]        r_hist [HISTORY_DEPTH];
    logic [AVG_W-1:0]        r_rd;

    // result fields
    logic                    r_show;
    logic [COL_W-1:0]        r_col;
    logic                    r_changed;
    logic                    r_ov;
    t_out_item               r_od;

    // combinational helpers
    logic signed [POS_W-1:0] pos_lo;
    logic signed [POS_W-1:0] pos_hi;
    logic signed [POS_W-1:0] win_s;
    logic [TOT_W-1:0]        total;
    logic                    is_start;
    logic                    tilt_chg;
    logic [NOW_W-1:0]        elapsed;
    logic                    keep;
    logic [AVG_W-1:0]        old_p;
    logic [SUM_W-1:0]        n_sum;
    logic [SL_W-1:0]         n_slot;
    logic [SUM_W-1:0]        avg_num;
    logic [AVG_PW-1:0]       avg_prod;
    logic [TURN_PROD_W-1:0]  turn_prod;
    logic [NOW_W-1:0]        tt_eff;
    logic                    pend_eff;
    logic                    fire;
    logic                    show;
    logic [POS_W-1:0]        pos_bits;
    logic signed [POS_W-1:0] stepped;
    logic signed [POS_W-1:0] n_pos;
    logic                    div_go;
    logic [NT_W-1:0]         div_dividend;
    logic [TOT_W-1:0]        div_divisor;
    logic                    div_busy;
    logic                    div_done;
    logic [NT_W-1:0]         div_quo;

    // geometry from latched widths
    always_comb begin
        win_s  = $signed(POS_W'(r_lat_w));
        pos_lo = -$signed(POS_W'(r_lat_m));
        pos_hi = POS_W'(win_s + $signed(POS_W'(r_lat_m)) - $signed(POS_W'(1)));
        total  = TOT_W'(r_lat_w) + (TOT_W'(r_lat_m) << 1);
    end

    // tilt edge and period check
    always_comb begin
        is_start = (r_req == REQ_START);
        tilt_chg = is_start || (r_tilt != r_last_tilt);
        elapsed  = r_now - r_swing;
        keep     = !is_start && tilt_chg &&
                   (elapsed >= NOW_W'(PERIOD_MIN)) && (elapsed <= NOW_W'(PERIOD_MAX));
        old_p    = r_hval[r_slot] ? r_rd : AVG_W'(PERIOD_MID);
        n_sum    = r_sum - SUM_W'(old_p) + SUM_W'(elapsed[AVG_W-1:0]);
        n_slot   = (r_slot == SL_W'(HISTORY_DEPTH - 1)) ? '0 : r_slot + SL_W'(1);
    end

    // rounded running average of the stored sum
    always_comb begin
        avg_num  = r_sum + SUM_W'(HISTORY_DEPTH / 2);
        avg_prod = AVG_PW'(avg_num) * AVG_PW'(AVG_MUL);
    end

    // turn schedule and turn check
    always_comb begin
        turn_prod = TURN_PROD_W'(r_avg) * TURN_PROD_W'(TURN_MUL);
        tt_eff    = r_chg ? r_now + NOW_W'(turn_prod[TURN_PROD_W-1:TURN_SHIFT]) : r_tt;
        pend_eff  = r_chg || r_pend;
        fire      = pend_eff && (r_now >= tt_eff);
    end

    // display step: show test, then move and clamp
    always_comb begin
        show     = (r_pos >= $signed(POS_W'(0))) && (r_pos < win_s);
        pos_bits = r_pos;
        stepped  = r_pos + POS_W'(r_dir);
        if (stepped < pos_lo) begin
            n_pos = pos_lo;
        end else if (stepped > pos_hi) begin
            n_pos = pos_hi;
        end else begin
            n_pos = stepped;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_win <= WINDOW_RESET;
            r_cfg_mar <= MARGIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WINDOW: r_cfg_win <= i_cfg_wdata[WIN_CFG_W-1:0];
                REG_MARGIN: r_cfg_mar <= i_cfg_wdata[MAR_CFG_W-1:0];
                default:    r_cfg_win <= r_cfg_win;
            endcase
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_req  <= i_in_data.req_type;
            r_now  <= i_in_data.now_ms;
            r_tilt <= i_in_data.tilt;
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat_w     <= clamp_window(WINDOW_RESET);
            r_lat_m     <= clamp_margin(MARGIN_RESET);
            r_last_tilt <= 1'b0;
            r_swing     <= '0;
            r_tt        <= '0;
            r_pend      <= 1'b0;
            r_chg       <= 1'b0;
            r_step_cnt  <= '0;
            r_dir       <= DIR_NONE;
            r_pos       <= '0;
            r_sum       <= SUM_W'(PERIOD_MID * HISTORY_DEPTH);
            r_avg       <= AVG_W'(PERIOD_MID);
            r_slot      <= '0;
            r_hval      <= '0;
            r_show      <= 1'b0;
            r_col       <= '0;
            r_changed   <= 1'b0;
        end else begin
            // tilt edge: restart on start, keep the period if in range
            if (i_cmd.tilt_eval) begin
                r_chg <= tilt_chg;
                if (is_start) begin
                    r_lat_w <= clamp_window(r_cfg_win);
                    r_lat_m <= clamp_margin(r_cfg_mar);
                    r_hval  <= '0;
                    r_slot  <= '0;
                    r_sum   <= SUM_W'(PERIOD_MID * HISTORY_DEPTH);
                    r_avg   <= AVG_W'(PERIOD_MID);
                end
                if (tilt_chg) begin
                    r_last_tilt <= r_tilt;
                    r_swing     <= r_now;
                    r_step_cnt  <= '0;
                end
                if (keep) begin
                    r_sum          <= n_sum;
                    r_hval[r_slot] <= 1'b1;
                    r_slot         <= n_slot;
                end
            end
            // rounded average of the kept periods, always within 8 bits
            if (i_cmd.avg_store) begin
                r_avg <= avg_prod[AVG_SH +: AVG_W];
            end
            // turn schedule and reversal
            if (i_cmd.turn_eval) begin
                r_tt      <= tt_eff;
                r_pend    <= pend_eff && !fire;
                r_changed <= fire;
                if (fire) begin
                    r_dir <= r_tilt ? DIR_DOWN : DIR_UP;
                    r_pos <= r_tilt ? pos_hi : pos_lo;
                end
            end
            // column output and position advance on update requests; a start clears the column
            if (i_cmd.step_eval) begin
                if (is_start) begin
                    r_show <= 1'b0;
                    r_col  <= '0;
                end else begin
                    r_show     <= show;
                    r_col      <= show ? COL_W'(pos_bits) : '0;
                    r_pos      <= n_pos;
                    r_step_cnt <= r_step_cnt + STEP_W'(1);
                end
            end
        end
    end

    // history memory, registered read at the current slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.tilt_eval && keep) begin
            r_hist[r_slot] <= elapsed[AVG_W-1:0];
        end
        r_rd <= r_hist[r_slot];
    end

    // serial divider for the next update time
    always_comb begin
        div_go       = i_cmd.div_nt;
        div_dividend = NT_W'(r_avg) * NT_W'(r_step_cnt);
        div_divisor  = total;
    end

    sdcs_div #(
        .DW (NT_W),
        .VW (TOT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (div_go),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_od.show_column       <= r_show;
            r_od.column_index      <= r_col;
            r_od.direction_changed <= r_changed;
            r_od.sweep_down        <= r_dir[1];
            r_od.next_time         <= r_swing + NOW_W'(div_quo);
        end
    end

    assign o_out_valid    = r_ov;
    assign o_out_data     = r_od;
    assign o_sts.keep     = keep;
    assign o_sts.div_busy = div_busy;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_ov || !i_out_stall;

endmodule

// ===== rtl/sdcs_ctrl.sv =====
module sdcs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  sdcs_pkg::t_sts i_sts,
    output sdcs_pkg::t_cmd o_cmd,
    output logic           o_in_stall
);

    import sdcs_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_TILT     = 4'd1;
    localparam logic [3:0] S_AVG      = 4'd2;
    localparam logic [3:0] S_TURN     = 4'd4;
    localparam logic [3:0] S_STEP     = 4'd5;
    localparam logic [3:0] S_NT_GO    = 4'd6;
    localparam logic [3:0] S_NT_WAIT  = 4'd7;
    localparam logic [3:0] S_OUT      = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_TILT;
                end
            end
            S_TILT: begin
                o_cmd.tilt_eval = 1'b1;
                n_state         = i_sts.keep ? S_AVG : S_TURN;
            end
            S_AVG: begin
                o_cmd.avg_store = 1'b1;
                n_state         = S_TURN;
            end
            S_TURN: begin
                o_cmd.turn_eval = 1'b1;
                n_state         = S_STEP;
            end
            S_STEP: begin
                o_cmd.step_eval = 1'b1;
                n_state         = S_NT_GO;
            end
            S_NT_GO: begin
                o_cmd.div_nt = 1'b1;
                n_state      = S_NT_WAIT;
            end
            S_NT_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== verif/tb_swing_display_column_sequencer_top.sv =====
`timescale 1ns / 100ps

module tb_swing_display_column_sequencer_top;
    import sdcs_pkg::*;

    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int SETTLE_CYCLES  = 80;
    localparam int HIST_N         = HISTORY_DEPTH_DEF;
    localparam int SLOT_W         = $clog2(HIST_N);
    localparam int TOTAL_W        = 12;
    localparam int TURN_PCT       = 38;
    localparam int PCT_SCALE      = 100;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = REG_WINDOW;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in_data   = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_data;
    logic                  i_out_stall = 1'b0;

    swing_display_column_sequencer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    always #5 i_clk = ~i_clk;

    // idle rates and run statistics
    int sender_gap_pct = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int items_sent     = 0;
    int starts_sent    = 0;
    int results_seen   = 0;
    int turns_seen     = 0;
    int cycle_cnt      = 0;

    // expected sequencer state
    logic [WIN_CFG_W-1:0]      win_reg;
    logic [MAR_CFG_W-1:0]      mar_reg;
    int                        vis_cols;
    int                        blank_cols;
    int                        span_cols;
    int                        pos_min;
    int                        pos_max;
    logic [AVG_W-1:0]          period_log [HIST_N];
    logic [SLOT_W-1:0]         log_slot;
    logic [TOTAL_W-1:0]        period_total;
    logic [AVG_W-1:0]          period_avg;
    logic [NOW_W-1:0]          swing_t0;
    logic [NOW_W-1:0]          turn_at;
    logic                      prev_tilt;
    logic                      turn_armed;
    int                        sweep_dir;
    int                        sweep_pos;
    logic [STEP_W-1:0]         step_cnt;
    t_out_item                 column_q [$];
    t_out_item                 due_column;

    // widths are clamped when a start takes them
    function automatic void latch_sizes();
        vis_cols = int'(win_reg);
        if (vis_cols < 1) vis_cols = 1;
        if (vis_cols > MAX_WINDOW_DEF) vis_cols = MAX_WINDOW_DEF;
        blank_cols = int'(mar_reg);
        if (blank_cols > MAX_MARGIN_DEF) blank_cols = MAX_MARGIN_DEF;
        span_cols = vis_cols + 2 * blank_cols;
        pos_min   = -blank_cols;
        pos_max   = pos_min + span_cols - 1;
    endfunction

    function automatic void clear_history();
        foreach (period_log[i]) period_log[i] = AVG_W'(PERIOD_MID);
        log_slot     = '0;
        period_total = TOTAL_W'(PERIOD_MID * HIST_N);
        period_avg   = AVG_W'(PERIOD_MID);
    endfunction

    function automatic void reset_model();
        win_reg    = WINDOW_RESET;
        mar_reg    = MARGIN_RESET;
        latch_sizes();
        clear_history();
        swing_t0   = '0;
        turn_at    = '0;
        prev_tilt  = 1'b0;
        turn_armed = 1'b0;
        sweep_dir  = 0;
        sweep_pos  = 0;
        step_cnt   = '0;
    endfunction

    // running average over the last kept swing periods
    function automatic void keep_period(input logic [NOW_W-1:0] elapsed);
        if (elapsed >= PERIOD_MIN && elapsed <= PERIOD_MAX) begin
            period_total         = period_total - TOTAL_W'(period_log[log_slot])
                                   + TOTAL_W'(elapsed);
            period_avg           = AVG_W'((period_total + HIST_N / 2) / HIST_N);
            period_log[log_slot] = elapsed[AVG_W-1:0];
            log_slot             = log_slot + SLOT_W'(1);
        end
    endfunction

    // tilt edge ends a swing; returns 1 when the sweep turns
    function automatic logic follow_tilt(input logic [NOW_W-1:0] now, input logic level);
        if (level != prev_tilt) begin
            prev_tilt  = level;
            keep_period(now - swing_t0);
            swing_t0   = now;
            step_cnt   = '0;
            turn_at    = now + period_avg * TURN_PCT / PCT_SCALE;
            turn_armed = 1'b1;
        end
        if (turn_armed && now >= turn_at) begin
            sweep_dir  = level ? -1 : 1;
            sweep_pos  = level ? pos_max : pos_min;
            turn_armed = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // expected column result for one accepted item
    function automatic t_out_item sequence_step(input t_in_item it);
        t_out_item r;
        r = '0;
        if (it.req_type == REQ_START) begin
            latch_sizes();
            clear_history();
            swing_t0  = it.now_ms;
            turn_at   = it.now_ms;
            prev_tilt = ~it.tilt;
            r.direction_changed = follow_tilt(it.now_ms, it.tilt);
        end else begin
            r.direction_changed = follow_tilt(it.now_ms, it.tilt);
            if (sweep_pos >= 0 && sweep_pos < vis_cols) begin
                r.show_column  = 1'b1;
                r.column_index = sweep_pos[COL_W-1:0];
            end
            sweep_pos = sweep_pos + sweep_dir;
            if (sweep_pos < pos_min) sweep_pos = pos_min;
            if (sweep_pos > pos_max) sweep_pos = pos_max;
            step_cnt = step_cnt + STEP_W'(1);
        end
        r.sweep_down = (sweep_dir < 0);
        r.next_time  = swing_t0 + period_avg * step_cnt / span_cols;
        return r;
    endfunction

    // send one item, predict its result on acceptance
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < sender_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        column_q.push_back(sequence_step(it));
        items_sent++;
        if (it.req_type == REQ_START) starts_sent++;
    endtask

    task automatic send_req(input logic req, input logic [NOW_W-1:0] now, input logic tilt);
        t_in_item it;
        it.req_type = req;
        it.now_ms   = now;
        it.tilt     = tilt;
        send_item(it);
    endtask

    // hold the sender until every expected result is back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (column_q.size() != 0) @(posedge i_clk);
    endtask

    // write both width registers; only called while idle
    task automatic configure(input logic [CFG_DATA_W-1:0] win, input logic [CFG_DATA_W-1:0] mar);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= REG_WINDOW;
        i_cfg_wdata <= win;
        @(posedge i_clk);
        win_reg      = win;
        i_cfg_idx   <= REG_MARGIN;
        i_cfg_wdata <= mar;
        @(posedge i_clk);
        mar_reg      = mar[MAR_CFG_W-1:0];
        i_cfg_we    <= 1'b0;
    endtask

    // updates before any start run on the reset state
    task automatic test_reset_state();
        send_req(REQ_UPDATE, 32'h0000_0000, 1'b0);
        send_req(REQ_UPDATE, 32'hFFFF_FFFF, 1'b1);
        send_req(REQ_UPDATE, 32'hFFFF_FFFF, 1'b1);
    endtask

    // periods just outside and at the limits, then the turn and a short sweep
    task automatic test_period_limits();
        send_req(REQ_START,  32'd1000, 1'b0);
        send_req(REQ_UPDATE, 32'd1100, 1'b1);
        send_req(REQ_UPDATE, 32'd1249, 1'b0);
        send_req(REQ_UPDATE, 32'd1399, 1'b1);
        send_req(REQ_UPDATE, 32'd1649, 1'b0);
        send_req(REQ_UPDATE, 32'd1900, 1'b1);
        send_req(REQ_UPDATE, 32'd1990, 1'b1);
        send_req(REQ_UPDATE, 32'd1991, 1'b1);
        send_req(REQ_UPDATE, 32'd1992, 1'b1);
    endtask

    // register values below and above their legal ranges, and the exact maxima
    task automatic test_width_clamps();
        drain();
        configure(7'd0, 7'h7F);
        send_req(REQ_START,  32'd5000, 1'b1);
        send_req(REQ_UPDATE, 32'd5100, 1'b1);
        send_req(REQ_UPDATE, 32'd5101, 1'b1);
        drain();
        configure(7'h7F, 7'd0);
        send_req(REQ_START,  32'd6000, 1'b0);
        send_req(REQ_UPDATE, 32'd6080, 1'b0);
        send_req(REQ_UPDATE, 32'd6081, 1'b0);
        drain();
        configure(7'd64, 7'd32);
        send_req(REQ_START,  32'd7000, 1'b1);
        send_req(REQ_UPDATE, 32'd7080, 1'b1);
    endtask

    // turn time wrapping past zero, and a time that wraps below the turn time
    task automatic test_turn_wrap();
        send_req(REQ_START,  32'hFFFF_FFF0, 1'b1);
        send_req(REQ_UPDATE, 32'hFFFF_FFF1, 1'b1);
        send_req(REQ_START,  32'hFFFF_FF00, 1'b0);
        send_req(REQ_UPDATE, 32'h0000_0010, 1'b0);
        send_req(REQ_UPDATE, 32'h0000_0020, 1'b1);
    endtask

    // one swing session: a start, then steady updates with the tilt flipping
    task automatic swing_run(input int n_items, input int dt_max);
        logic [NOW_W-1:0] now;
        logic             level;
        int               since_flip;
        int               half_period;
        int               dt;
        int               pick;
        if ($urandom_range(9) == 0) begin
            now = 32'hFFFF_FFFF - $urandom_range(3000);
        end else begin
            now = $urandom;
        end
        level = 1'($urandom_range(1));
        send_req(REQ_START, now, level);
        since_flip  = 0;
        half_period = $urandom_range(140, 260);
        repeat (n_items) begin
            dt         = $urandom_range(1, dt_max);
            now        = now + dt;
            since_flip = since_flip + dt;
            if (since_flip >= half_period) begin
                level       = ~level;
                since_flip  = 0;
                half_period = $urandom_range(140, 260);
            end
            pick = $urandom_range(49);
            if (pick == 0) begin
                level      = 1'($urandom_range(1));
                since_flip = 0;
                send_req(REQ_START, now, level);
            end else if (pick == 1) begin
                send_req(1'($urandom_range(1)), $urandom, 1'($urandom_range(1)));
            end else begin
                if (pick == 2) drain();
                send_req(REQ_UPDATE, now, level);
            end
        end
    endtask

    task automatic test_random_phase(input int gap_pct, input int stall_pct, input int n_items,
                                     input logic [CFG_DATA_W-1:0] win,
                                     input logic [CFG_DATA_W-1:0] mar, input bit reshuffle);
        int sent;
        int len;
        sender_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        drain();
        configure(win, mar);
        while (sent < n_items) begin
            len = $urandom_range(20, 120);
            if (reshuffle && sent > 0) begin
                drain();
                configure(7'($urandom_range(127)), 7'($urandom_range(127)));
            end
            swing_run(len, $urandom_range(1, 8));
            sent = sent + len + 1;
        end
    endtask

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    // compare each result with the oldest expected one
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            results_seen++;
            if (o_out_data.direction_changed === 1'b1) turns_seen++;
            if (column_q.size() == 0) begin
                mismatches++;
                $display("%0t: result with none expected, got %p", $time, o_out_data);
            end else begin
                due_column = column_q.pop_front();
                check_field("show_column", 64'(due_column.show_column),
                            64'(o_out_data.show_column));
                check_field("column_index", 64'(due_column.column_index),
                            64'(o_out_data.column_index));
                check_field("direction_changed", 64'(due_column.direction_changed),
                            64'(o_out_data.direction_changed));
                check_field("sweep_down", 64'(due_column.sweep_down),
                            64'(o_out_data.sweep_down));
                check_field("next_time", 64'(due_column.next_time),
                            64'(o_out_data.next_time));
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == TIMEOUT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        reset_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_period_limits();
        test_width_clamps();
        test_turn_wrap();
        test_random_phase(23, 87, 500, 7'd64, 7'd32, 1'b0);
        test_random_phase(87, 23, 500, 7'd1, 7'd0, 1'b0);
        test_random_phase(0, 0, 500, WINDOW_RESET, CFG_DATA_W'(MARGIN_RESET), 1'b1);

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("sent %0d items (%0d starts), checked %0d results with %0d sweep turns",
                 items_sent, starts_sent, results_seen, turns_seen);
        $display("window and margin widths ran from clamped extremes to random values");
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
